[src/fpud_pkg.sv]
// shared constants for the fixed-point unsigned divider
`default_nettype none

package fpud_pkg;

    // default operand and result width
    localparam int DATA_WIDTH_DEF = 32;

    // fraction count register
    localparam int               FRAC_WIDTH = 6;
    localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = FRAC_WIDTH'(16);
    localparam int               FRAC_MAX   = (2 ** FRAC_WIDTH) - 1;

endpackage : fpud_pkg

`default_nettype wire

[src/fixed_point_unsigned_divider.sv]
// pipelined restoring divider giving floor(dividend * 2^frac_bits / divisor)
//
//   channel   direction  handshake                   payload
//   input     in         i_valid / o_stall           i_dividend, i_divisor
//   output    out        o_valid / i_stall           o_quotient
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_data (frac_bits)
//
// one transaction enters per cycle while o_stall is low; the pipeline is one load
// stage with the numerator shift, one restoring step per pipeline stage, and the
// output register.
// reset empties the pipeline and sets frac_bits to 16.
// a stalled result is held in the output register; one more result is caught
// in a skid register, after which o_stall rises and the whole pipeline holds.
`default_nettype none

module fixed_point_unsigned_divider import fpud_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [FRAC_WIDTH-1:0] i_cfg_data,
    // input transactions
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    // result transactions
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [DATA_WIDTH-1:0]      o_quotient
);

    // one step for every numerator bit, numerator wide enough for any shift
    localparam int STEPS = DATA_WIDTH + FRAC_MAX;
    localparam int NUM_W = DATA_WIDTH + FRAC_MAX;

    logic [FRAC_WIDTH-1:0] r_frac_bits;

    logic                  r_pipe_v [0:STEPS];
    logic [NUM_W-1:0]      r_num    [0:STEPS];
    logic [DATA_WIDTH-1:0] r_rem    [0:STEPS];
    logic [DATA_WIDTH-1:0] r_den    [0:STEPS];
    logic [DATA_WIDTH-1:0] r_quo    [0:STEPS];

    logic                  r_out_v;
    logic [DATA_WIDTH-1:0] r_out_q;
    logic                  r_skid_v;
    logic [DATA_WIDTH-1:0] r_skid_q;
    logic                  n_out_v;
    logic [DATA_WIDTH-1:0] n_out_q;
    logic                  n_skid_v;
    logic [DATA_WIDTH-1:0] n_skid_q;

    logic                  advance;
    logic                  take;
    logic                  deliver;

    // pipeline moves whenever the skid register is free
    assign advance = !r_skid_v;
    assign o_stall = r_skid_v;

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= FRAC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frac_bits <= i_cfg_data;
        end
    end

    // load stage: place the dividend at its fixed-point position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_v[0] <= 1'b0;
        end else if (advance) begin
            r_pipe_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_num[0] <= NUM_W'(i_dividend) << r_frac_bits;
            r_rem[0] <= '0;
            r_den[0] <= i_divisor;
            r_quo[0] <= '0;
        end
    end

    // one restoring step per stage
    for (genvar s = 1; s <= STEPS; s++) begin : g_step
        logic [DATA_WIDTH:0] trial;
        logic [DATA_WIDTH:0] diff;
        logic                fits;

        // bring down the next numerator bit and trial subtract
        assign trial = {r_rem[s-1], r_num[s-1][NUM_W-1]};
        assign diff  = trial - {1'b0, r_den[s-1]};
        assign fits  = trial >= {1'b0, r_den[s-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pipe_v[s] <= 1'b0;
            end else if (advance) begin
                r_pipe_v[s] <= r_pipe_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_num[s] <= {r_num[s-1][NUM_W-2:0], 1'b0};
                r_rem[s] <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                r_den[s] <= r_den[s-1];
                r_quo[s] <= {r_quo[s-1][DATA_WIDTH-2:0], fits};
            end
        end
    end

    // output register with one skid entry behind it
    assign take    = r_out_v && !i_stall;
    assign deliver = advance && r_pipe_v[STEPS];

    always_comb begin
        n_out_v  = r_out_v;
        n_out_q  = r_out_q;
        n_skid_v = r_skid_v;
        n_skid_q = r_skid_q;
        if (r_skid_v) begin
            if (take) begin
                n_out_q  = r_skid_q;
                n_skid_v = 1'b0;
            end
        end else if (deliver) begin
            if (!r_out_v || take) begin
                n_out_v = 1'b1;
                n_out_q = r_quo[STEPS];
            end else begin
                n_skid_v = 1'b1;
                n_skid_q = r_quo[STEPS];
            end
        end else if (take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_q  <= n_out_q;
        r_skid_q <= n_skid_q;
    end

    assign o_valid    = r_out_v;
    assign o_quotient = r_out_q;

endmodule : fixed_point_unsigned_divider

`default_nettype wire

[dv/tb.sv]
// self-checking testbench for the fixed-point unsigned divider
`default_nettype none

module tb;
    import fpud_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int LATENCY     = DW + FRAC_MAX + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // clock, reset and block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [FRAC_WIDTH-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [DW-1:0]         i_dividend  = '0;
    logic [DW-1:0]         i_divisor   = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [DW-1:0]         o_quotient;

    // scoreboard state
    logic [DW-1:0]         quotient_q[$];
    logic [FRAC_WIDTH-1:0] frac_copy = FRAC_RESET;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;

    // idling controls
    int burst_left    = 0;
    int gap_max       = 0;
    int stall_pct     = 0;
    int stall_len_max = 1;
    int stall_run     = 0;
    logic stall_now   = 1'b0;

    fixed_point_unsigned_divider #(
        .DATA_WIDTH (DW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_quotient  (o_quotient)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter with a generous limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("fixed_point_unsigned_divider test failed");
        $finish;
    end

    // low bits of floor(num * 2^frac / den), all ones for a zero divisor
    function automatic logic [DW-1:0] fixed_quotient(logic [DW-1:0] num, logic [DW-1:0] den,
                                                      logic [FRAC_WIDTH-1:0] frac);
        logic [127:0] wide;
        if (den == '0)
            return '1;
        wide = {{(128-DW){1'b0}}, num} << frac;
        wide = wide / {{(128-DW){1'b0}}, den};
        return wide[DW-1:0];
    endfunction

    // operand with a random magnitude, some zeros and all-ones
    function automatic logic [DW-1:0] random_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = DW'($urandom_range(1, 16));
            default: v = DW'($urandom) >> $urandom_range(0, DW - 1);
        endcase
        return v;
    endfunction

    task automatic note_mismatch(string what, logic [DW-1:0] exp_q, logic [DW-1:0] got_q);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch (%s): expected %h, got %h", what, exp_q, got_q);
    endtask

    // receiver stall pattern: runs of random length
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_now = ($urandom_range(0, 99) < stall_pct);
            stall_run = $urandom_range(1, stall_len_max);
        end
        stall_run--;
        i_stall <= stall_now;
    end

    // monitor: tracks config writes, predicts accepted transactions, checks results
    always @(posedge i_clk) begin
        logic [DW-1:0] want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                frac_copy = i_cfg_data;
            if (i_valid && !o_stall)
                quotient_q.push_back(fixed_quotient(i_dividend, i_divisor, frac_copy));
            if (o_valid && !i_stall) begin
                if (quotient_q.size() == 0) begin
                    note_mismatch("unexpected result", 'x, o_quotient);
                end else begin
                    want = quotient_q.pop_front();
                    if (o_quotient !== want)
                        note_mismatch("quotient", want, o_quotient);
                end
            end
        end
    end

    // one division transaction, with bursts and gaps on the sending side
    task automatic send_division(logic [DW-1:0] num, logic [DW-1:0] den);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_dividend <= num;
        i_divisor  <= den;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // stop sending and wait for every pending result
    task automatic wait_drained();
        i_valid    <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (quotient_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_frac(logic [FRAC_WIDTH-1:0] frac);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= frac;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int gap, int pct, int len);
        gap_max       = gap;
        stall_pct     = pct;
        stall_len_max = len;
    endtask

    // default fraction count straight after reset, operand extremes
    task automatic check_reset_frac();
        set_idling(2, 30, 4);
        send_division('0, 32'd1);
        send_division('1, 32'd1);
        send_division('1, '1);
        send_division(32'd1, '1);
        send_division(32'h1234_5678, 32'd3);
    endtask

    // zero divisor gives all ones whatever the dividend
    task automatic check_zero_divisor();
        send_division('0, '0);
        send_division('1, '0);
        send_division(32'h8000_0001, '0);
    endtask

    // quotient wider than the result wraps
    task automatic check_wrapping_quotient();
        send_division(32'hffff_0000, 32'd1);
        send_division(32'h0001_0000, 32'd1);
        send_division(32'h7fff_ffff, 32'd2);
    endtask

    // fraction count at zero, at full width, just above it and at the field maximum
    task automatic check_frac_extremes();
        write_frac(FRAC_WIDTH'(0));
        send_division('1, 32'd1);
        send_division(32'd7, 32'd2);
        write_frac(FRAC_WIDTH'(DW));
        send_division(32'd1, 32'd2);
        send_division('1, '1);
        send_division(32'd3, '0);
        write_frac(FRAC_WIDTH'(DW + 1));
        send_division(32'd1, 32'd5);
        write_frac(FRAC_WIDTH'(FRAC_MAX));
        send_division('1, 32'd1);
        send_division(32'd1, 32'd3);
        send_division('1, 32'h8000_0000);
    endtask

    // random operands over several fraction counts and idling patterns
    task automatic check_random_divisions();
        logic [FRAC_WIDTH-1:0] frac;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: frac = '0;
                1: frac = FRAC_WIDTH'(DW);
                2: frac = FRAC_WIDTH'(FRAC_MAX);
                default: frac = ($urandom_range(0, 3) == 0) ?
                               FRAC_WIDTH'($urandom_range(0, FRAC_MAX)) :
                               FRAC_WIDTH'($urandom_range(0, DW));
            endcase
            write_frac(frac);
            case ($urandom_range(0, 2))
                0: set_idling(0, 0, 1);
                1: set_idling(3, 25, 6);
                default: set_idling(8, 70, 12);
            endcase
            for (int n = 0; n < 50; n++)
                send_division(random_operand(), random_operand());
        end
    endtask

    // back-to-back transactions with no gaps and no stalls
    task automatic check_full_rate();
        write_frac(FRAC_RESET);
        set_idling(0, 0, 1);
        for (int n = 0; n < 40; n++)
            send_division(DW'($urandom), DW'($urandom) >> $urandom_range(0, DW - 1));
    endtask

    // test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reset_frac();
        check_zero_divisor();
        check_wrapping_quotient();
        check_frac_extremes();
        check_random_divisions();
        check_full_rate();
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (quotient_q.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0) begin
            $display("fixed_point_unsigned_divider test passed");
        end else begin
            $display("fixed_point_unsigned_divider test failed");
        end
        $finish;
    end

endmodule : tb

`default_nettype wire

[sim.f]
src/fpud_pkg.sv
src/fixed_point_unsigned_divider.sv
dv/tb.sv
